// ----- rtl/u8dec_pkg.sv -----
// Shared types, codes and counter helpers for the UTF-8 to UTF-16 decoder.
// Used by the front, queue, back and top-level modules; no dependencies.

package u8dec_pkg;

  localparam int COUNT_BITS = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_UNIT  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [2:0] REASON_STRAY      = 3'd0;
  localparam logic [2:0] REASON_OVERLONG   = 3'd1;
  localparam logic [2:0] REASON_INCOMPLETE = 3'd2;
  localparam logic [2:0] REASON_SURROGATE  = 3'd3;
  localparam logic [2:0] REASON_ABOVE_MAX  = 3'd4;
  localparam logic [2:0] REASON_BAD_START  = 3'd5;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        pair;
    logic [19:0] scalar;
    logic [2:0]  reason;
    logic [31:0] offset;
    logic [7:0]  err_byte;
    logic [31:0] line;
    logic        final_result;
  } op_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
  endfunction

  function automatic logic [31:0] clip32(input count_t v);
    logic [COUNT_BITS+31:0] wide;
    wide = {32'b0, v};
    if (wide > (COUNT_BITS+32)'(32'hFFFF_FFFF)) begin
      clip32 = 32'hFFFF_FFFF;
    end else begin
      clip32 = wide[31:0];
    end
  endfunction

endpackage

// ----- rtl/u8dec_front.sv -----
// Front end: decodes one UTF-8 byte per beat, tracks offsets and lines, and
// emits one classified operation per byte that yields a result. Uses u8dec_pkg.

module u8dec_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_text,
  output logic             op_valid,
  output u8dec_pkg::op_t   op
);

  logic [1:0]         bytes_pending, bytes_pending_next;
  logic [1:0]         sequence_length, sequence_length_next;
  logic [20:0]        partial_scalar, partial_scalar_next;
  logic [7:0]         lead_byte, lead_byte_next;
  u8dec_pkg::count_t  sequence_start, sequence_start_next;
  u8dec_pkg::count_t  byte_position, byte_position_next;
  u8dec_pkg::count_t  newline_count, newline_count_next;
  logic               failed, failed_next;

  logic               is_err;
  logic               is_unit;
  logic [2:0]         err_reason;
  u8dec_pkg::count_t  err_off;
  logic [7:0]         err_byte;
  logic [20:0]        cp;
  logic [20:0]        cp_off;
  logic [1:0]         len;

  always_comb begin
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    partial_scalar_next  = partial_scalar;
    lead_byte_next       = lead_byte;
    sequence_start_next  = sequence_start;
    byte_position_next   = byte_position;
    newline_count_next   = newline_count;
    failed_next          = failed;
    op_valid   = 1'b0;
    op         = '0;
    is_err     = 1'b0;
    is_unit    = 1'b0;
    err_reason = u8dec_pkg::REASON_STRAY;
    err_off    = byte_position;
    err_byte   = data_byte;
    len        = 2'd0;
    cp         = {partial_scalar[14:0], data_byte[5:0]};
    cp_off     = cp - 21'h10000;

    if (!failed) begin
      byte_position_next = u8dec_pkg::sat_inc(byte_position);
      if (bytes_pending == 2'd0) begin
        priority if (data_byte < 8'h80) begin
          is_unit = 1'b1;
          op.scalar = {12'b0, data_byte};
          if (data_byte == 8'h0A) begin
            newline_count_next = u8dec_pkg::sat_inc(newline_count);
          end
        end else if (data_byte < 8'hC2) begin
          is_err = 1'b1;
          err_reason = (data_byte < 8'hC0) ? u8dec_pkg::REASON_STRAY
                                            : u8dec_pkg::REASON_OVERLONG;
        end else if (data_byte < 8'hF5) begin
          len = (data_byte < 8'hE0) ? 2'd1 : (data_byte < 8'hF0) ? 2'd2 : 2'd3;
          lead_byte_next       = data_byte;
          sequence_start_next  = byte_position;
          sequence_length_next = len;
          bytes_pending_next   = len;
          partial_scalar_next  = (len == 2'd1) ? {16'b0, data_byte[4:0]} :
                                 (len == 2'd2) ? {17'b0, data_byte[3:0]} :
                                                 {18'b0, data_byte[2:0]};
          if (end_of_text) begin
            is_err = 1'b1;
            err_reason = u8dec_pkg::REASON_INCOMPLETE;
          end
        end else begin
          is_err = 1'b1;
          err_reason = u8dec_pkg::REASON_BAD_START;
        end
      end else begin
        err_off  = sequence_start;
        err_byte = lead_byte;
        if (data_byte[7:6] != 2'b10) begin
          is_err = 1'b1;
          err_reason = u8dec_pkg::REASON_INCOMPLETE;
        end else begin
          partial_scalar_next = cp;
          bytes_pending_next  = bytes_pending - 2'd1;
          if (bytes_pending != 2'd1) begin
            if (end_of_text) begin
              is_err = 1'b1;
              err_reason = u8dec_pkg::REASON_INCOMPLETE;
            end
          end else begin
            sequence_length_next = 2'd0;
            partial_scalar_next  = '0;
            unique case (sequence_length)
              2'd1: begin
                is_unit = 1'b1;
                op.scalar = cp[19:0];
              end
              2'd2: begin
                priority if (cp < 21'h800) begin
                  is_err = 1'b1;
                  err_reason = u8dec_pkg::REASON_OVERLONG;
                end else if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
                  is_err = 1'b1;
                  err_reason = u8dec_pkg::REASON_SURROGATE;
                end else if (!(cp == 21'hFEFF && sequence_start == '0)) begin
                  is_unit = 1'b1;
                  op.scalar = cp[19:0];
                end
              end
              default: begin
                priority if (cp < 21'h10000) begin
                  is_err = 1'b1;
                  err_reason = u8dec_pkg::REASON_OVERLONG;
                end else if (cp > 21'h10FFFF) begin
                  is_err = 1'b1;
                  err_reason = u8dec_pkg::REASON_ABOVE_MAX;
                end else begin
                  is_unit = 1'b1;
                  op.pair = 1'b1;
                  op.scalar = cp_off[19:0];
                end
              end
            endcase
          end
        end
      end

      if (is_err) begin
        op_valid        = 1'b1;
        op              = '0;
        op.kind         = u8dec_pkg::KIND_ERROR;
        op.reason       = err_reason;
        op.offset       = u8dec_pkg::clip32(err_off);
        op.err_byte     = err_byte;
        op.line         = u8dec_pkg::clip32(u8dec_pkg::sat_inc(newline_count));
        op.final_result = 1'b1;
        failed_next     = 1'b1;
      end else if (is_unit) begin
        op_valid        = 1'b1;
        op.kind         = u8dec_pkg::KIND_UNIT;
        op.final_result = end_of_text;
      end else if (end_of_text) begin
        op_valid        = 1'b1;
        op              = '0;
        op.kind         = u8dec_pkg::KIND_END;
        op.final_result = 1'b1;
      end
    end

    if (end_of_text) begin
      bytes_pending_next   = '0;
      sequence_length_next = '0;
      partial_scalar_next  = '0;
      lead_byte_next       = '0;
      sequence_start_next  = '0;
      byte_position_next   = '0;
      newline_count_next   = '0;
      failed_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= '0;
      sequence_length <= '0;
      partial_scalar  <= '0;
      lead_byte       <= '0;
      sequence_start  <= '0;
      byte_position   <= '0;
      newline_count   <= '0;
      failed          <= 1'b0;
    end else if (accept) begin
      bytes_pending   <= bytes_pending_next;
      sequence_length <= sequence_length_next;
      partial_scalar  <= partial_scalar_next;
      lead_byte       <= lead_byte_next;
      sequence_start  <= sequence_start_next;
      byte_position   <= byte_position_next;
      newline_count   <= newline_count_next;
      failed          <= failed_next;
    end
  end

endmodule

// ----- rtl/u8dec_queue.sv -----
// Short operation queue between the decoding front and the result back end.
// Uses u8dec_pkg for the operation record and depth.

module u8dec_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  u8dec_pkg::op_t   wr_op,
  input  logic             rd_en,
  output u8dec_pkg::op_t   rd_op,
  output logic             q_full,
  output logic             q_empty
);

  u8dec_pkg::op_t                  mem [u8dec_pkg::QUEUE_DEPTH];
  logic [u8dec_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [u8dec_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [u8dec_pkg::QPTR_BITS:0]   count;

  assign q_full  = (count == (u8dec_pkg::QPTR_BITS+1)'(u8dec_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_op   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/u8dec_back.sv -----
// Back end: expands queued operations into results, splitting supplementary
// scalars into a surrogate pair, and holds each result in an output register.
// Uses u8dec_pkg.

module u8dec_back (
  input  logic             clk,
  input  logic             rst,
  input  u8dec_pkg::op_t   q_op,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       kind,
  output logic [15:0]      code_unit,
  output logic [2:0]       error_reason,
  output logic [31:0]      error_offset,
  output logic [7:0]       error_byte,
  output logic [31:0]      error_line,
  output logic             final_result
);

  logic        out_valid;
  logic        low_pending;
  logic [15:0] low_unit;
  logic        low_final;
  logic        slot_free;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign q_pop     = slot_free && !low_pending && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      low_pending <= 1'b0;
    end else if (slot_free) begin
      if (low_pending) begin
        out_valid   <= 1'b1;
        low_pending <= 1'b0;
      end else begin
        out_valid   <= !q_empty;
        low_pending <= !q_empty && q_op.pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (low_pending) begin
        kind         <= u8dec_pkg::KIND_UNIT;
        code_unit    <= low_unit;
        error_reason <= '0;
        error_offset <= '0;
        error_byte   <= '0;
        error_line   <= '0;
        final_result <= low_final;
      end else begin
        kind         <= q_op.kind;
        code_unit    <= q_op.pair ? (16'hD800 | {6'b0, q_op.scalar[19:10]})
                                  : q_op.scalar[15:0];
        error_reason <= q_op.reason;
        error_offset <= q_op.offset;
        error_byte   <= q_op.err_byte;
        error_line   <= q_op.line;
        final_result <= q_op.pair ? 1'b0 : q_op.final_result;
        low_unit     <= 16'hDC00 | {6'b0, q_op.scalar[9:0]};
        low_final    <= q_op.final_result;
      end
    end
  end

endmodule

// ----- rtl/utf8_to_utf16_validating_decoder_unit.sv -----
// Top level of the validating UTF-8 to UTF-16 decoder.
// Instantiates u8dec_front, u8dec_queue and u8dec_back; uses u8dec_pkg.

// One UTF-8 byte is taken per clock while full is low; the decoder front
// settles each byte combinationally and hands any result to a four-entry
// queue. The back end drains that queue through an output register at one
// result per cycle while pop is held, so a result passes through the queue
// and then the output register before it shows on the ports. A four-byte
// sequence yields a surrogate pair, high unit first then low unit; full
// rises only when the queue holds four pending operations. Bytes after an
// error report up to the end of the text are consumed silently, and all
// decoder state returns to reset after each byte flagged end_of_text.

module utf8_to_utf16_validating_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] code_unit,
  output logic [2:0]  error_reason,
  output logic [31:0] error_offset,
  output logic [7:0]  error_byte,
  output logic [31:0] error_line,
  output logic        final_result
);

  logic           accept;
  logic           op_valid;
  u8dec_pkg::op_t op;
  u8dec_pkg::op_t q_op;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  u8dec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .op_valid    (op_valid),
    .op          (op)
  );

  u8dec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && op_valid),
    .wr_op   (op),
    .rd_en   (q_pop),
    .rd_op   (q_op),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  u8dec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_op         (q_op),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .code_unit    (code_unit),
    .error_reason (error_reason),
    .error_offset (error_offset),
    .error_byte   (error_byte),
    .error_line   (error_line),
    .final_result (final_result)
  );

endmodule

// ----- bench/tb_utf8_to_utf16_validating_decoder_unit.sv -----
// Self-checking bench for utf8_to_utf16_validating_decoder_unit: UTF-8 texts in,
// UTF-16 units, error reports and end markers out, checked against a local decoder.
// Depends on rtl/u8dec_pkg.sv and the decoder RTL.

module tb_utf8_to_utf16_validating_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int BYTES_WANTED = 1550;
  localparam int QUIET_TAIL = 150;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code;
    logic [2:0]  reason;
    logic [31:0] offset;
    logic [7:0]  ebyte;
    logic [31:0] line;
    logic        fin;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [15:0] code_unit;
  logic [2:0]  error_reason;
  logic [31:0] error_offset;
  logic [7:0]  error_byte;
  logic [31:0] error_line;
  logic        final_result;

  utf8_to_utf16_validating_decoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .end_of_text  (end_of_text),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .code_unit    (code_unit),
    .error_reason (error_reason),
    .error_offset (error_offset),
    .error_byte   (error_byte),
    .error_line   (error_line),
    .final_result (final_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_beat_t bytes_to_send[$];
  result_t    results_due[$];
  logic [7:0] text_buf[$];

  // decoder state mirror
  logic [1:0]           seq_owed;
  logic [1:0]           seq_len;
  logic [20:0]          seq_bits;
  logic [7:0]           seq_lead;
  u8dec_pkg::count_t    seq_start;
  u8dec_pkg::count_t    byte_pos;
  u8dec_pkg::count_t    nl_seen;
  logic                 text_failed;

  int mismatches = 0;
  int cycles = 0;
  int texts_built = 0;
  int bytes_built = 0;
  int bytes_taken = 0;
  int units_seen = 0;
  int errors_seen = 0;
  int ends_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic quiet = 1'b0;

  function automatic u8dec_pkg::count_t bump(input u8dec_pkg::count_t v);
    return (v == '1) ? v : v + u8dec_pkg::count_t'(1);
  endfunction

  function automatic logic [31:0] clip_word(input u8dec_pkg::count_t v);
    longint unsigned w;
    w = longint'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  task automatic restart_text();
    seq_owed = '0;
    seq_len = '0;
    seq_bits = '0;
    seq_lead = '0;
    seq_start = '0;
    byte_pos = '0;
    nl_seen = '0;
    text_failed = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    result_t           r [2];
    int                n;
    u8dec_pkg::count_t at;
    logic [20:0]       cp;
    logic              bad;
    logic [2:0]        why;
    u8dec_pkg::count_t why_at;
    logic [7:0]        why_byte;
    n = 0;
    bad = 1'b0;
    why = u8dec_pkg::REASON_STRAY;
    why_at = '0;
    why_byte = '0;
    r[0] = '0;
    r[1] = '0;
    if (text_failed) begin
      if (eot) restart_text();
      return;
    end
    at = byte_pos;
    byte_pos = bump(byte_pos);
    if (seq_owed == 0) begin
      if (b < 8'h80) begin
        r[n].kind = u8dec_pkg::KIND_UNIT;
        r[n].code = {8'h00, b};
        n++;
        if (b == 8'h0A) nl_seen = bump(nl_seen);
      end else if (b < 8'hC2) begin
        bad = 1'b1;
        why = (b < 8'hC0) ? u8dec_pkg::REASON_STRAY : u8dec_pkg::REASON_OVERLONG;
        why_at = at;
        why_byte = b;
      end else if (b < 8'hF5) begin
        seq_lead = b;
        seq_start = at;
        seq_len = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
        seq_owed = seq_len;
        seq_bits = {16'h0, b[4:0]} & ((seq_len == 2'd1) ? 21'h1F :
                                      (seq_len == 2'd2) ? 21'h0F : 21'h07);
        if (eot) begin
          bad = 1'b1;
          why = u8dec_pkg::REASON_INCOMPLETE;
          why_at = seq_start;
          why_byte = seq_lead;
        end
      end else begin
        bad = 1'b1;
        why = u8dec_pkg::REASON_BAD_START;
        why_at = at;
        why_byte = b;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;
      why = u8dec_pkg::REASON_INCOMPLETE;
      why_at = seq_start;
      why_byte = seq_lead;
    end else begin
      seq_bits = {seq_bits[14:0], b[5:0]};
      seq_owed = seq_owed - 2'd1;
      if (seq_owed != 0) begin
        if (eot) begin
          bad = 1'b1;
          why = u8dec_pkg::REASON_INCOMPLETE;
          why_at = seq_start;
          why_byte = seq_lead;
        end
      end else begin
        cp = seq_bits;
        why_at = seq_start;
        why_byte = seq_lead;
        if (seq_len == 2'd1) begin
          r[n].kind = u8dec_pkg::KIND_UNIT;
          r[n].code = cp[15:0];
          n++;
        end else if (seq_len == 2'd2) begin
          if (cp < 21'h800) begin
            bad = 1'b1;
            why = u8dec_pkg::REASON_OVERLONG;
          end else if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
            bad = 1'b1;
            why = u8dec_pkg::REASON_SURROGATE;
          end else if (!(cp == 21'hFEFF && seq_start == 0)) begin
            r[n].kind = u8dec_pkg::KIND_UNIT;
            r[n].code = cp[15:0];
            n++;
          end
        end else begin
          if (cp < 21'h10000) begin
            bad = 1'b1;
            why = u8dec_pkg::REASON_OVERLONG;
          end else if (cp > 21'h10FFFF) begin
            bad = 1'b1;
            why = u8dec_pkg::REASON_ABOVE_MAX;
          end else begin
            cp = cp - 21'h10000;
            r[0].kind = u8dec_pkg::KIND_UNIT;
            r[0].code = 16'hD800 | {6'h0, cp[19:10]};
            r[1].kind = u8dec_pkg::KIND_UNIT;
            r[1].code = 16'hDC00 | {6'h0, cp[9:0]};
            n = 2;
          end
        end
        if (!bad) begin
          seq_len = '0;
          seq_bits = '0;
        end
      end
    end
    if (bad) begin
      r[0] = '0;
      r[0].kind = u8dec_pkg::KIND_ERROR;
      r[0].reason = why;
      r[0].offset = clip_word(why_at);
      r[0].ebyte = why_byte;
      r[0].line = clip_word(bump(nl_seen));
      r[0].fin = 1'b1;
      n = 1;
      if (eot) restart_text();
      else text_failed = 1'b1;
    end else if (eot) begin
      if (n == 0) begin
        r[0].kind = u8dec_pkg::KIND_END;
        n = 1;
      end
      r[n-1].fin = 1'b1;
      restart_text();
    end
    for (int i = 0; i < n; i++) results_due.insert(results_due.size(), r[i]);
  endtask

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t w;
    if (results_due.size() == 0) begin
      note_mismatch($sformatf("result kind %0d with nothing due", kind));
      return;
    end
    w = results_due.pop_front();
    check_field("kind", 32'(kind), 32'(w.kind));
    check_field("code_unit", 32'(code_unit), 32'(w.code));
    check_field("error_reason", 32'(error_reason), 32'(w.reason));
    check_field("error_offset", error_offset, w.offset);
    check_field("error_byte", 32'(error_byte), 32'(w.ebyte));
    check_field("error_line", error_line, w.line);
    check_field("final_result", 32'(final_result), 32'(w.fin));
    case (w.kind)
      u8dec_pkg::KIND_UNIT:  units_seen++;
      u8dec_pkg::KIND_ERROR: errors_seen++;
      default:               ends_seen++;
    endcase
  endtask

  task automatic append_byte(input logic [7:0] v);
    text_buf.insert(text_buf.size(), v);
  endtask

  task automatic add_scalar(input logic [20:0] s, input int n);
    case (n)
      1: append_byte({1'b0, s[6:0]});
      2: begin
        append_byte({3'b110, s[10:6]});
        append_byte({2'b10, s[5:0]});
      end
      3: begin
        append_byte({4'b1110, s[15:12]});
        append_byte({2'b10, s[11:6]});
        append_byte({2'b10, s[5:0]});
      end
      default: begin
        append_byte({5'b11110, s[20:18]});
        append_byte({2'b10, s[17:12]});
        append_byte({2'b10, s[11:6]});
        append_byte({2'b10, s[5:0]});
      end
    endcase
  endtask

  task automatic add_fault(input logic last);
    int f;
    int n;
    int drop;
    f = (last && $urandom_range(0, 2) == 0) ? 9 : $urandom_range(0, 9);
    case (f)
      0: append_byte(8'($urandom_range(0, 255)));
      1: append_byte(8'($urandom_range(8'h80, 8'hBF)));
      2: add_scalar(21'($urandom_range(0, 32'h7F)), 2);
      3: add_scalar(21'($urandom_range(0, 32'h7FF)), 3);
      4: add_scalar(21'($urandom_range(0, 32'hFFFF)), 4);
      5: add_scalar(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
      6: add_scalar(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
      7: append_byte(8'($urandom_range(8'hF5, 8'hFF)));
      default: begin
        n = $urandom_range(2, 4);
        case (n)
          2: add_scalar(21'($urandom_range(32'h80, 32'h7FF)), 2);
          3: add_scalar(21'($urandom_range(32'h800, 32'hFFFF)), 3);
          default: add_scalar(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
        endcase
        drop = $urandom_range(1, n - 1);
        repeat (drop) void'(text_buf.pop_back());
      end
    endcase
  endtask

  task automatic build_text();
    int          chars;
    int          pick;
    logic        clean;
    logic [20:0] s;
    text_buf.delete();
    clean = ($urandom_range(0, 9) < 6);
    chars = $urandom_range(1, 12);
    for (int k = 0; k < chars; k++) begin
      pick = $urandom_range(0, 99);
      if (k == 0 && pick < 8) begin
        add_scalar(21'hFEFF, 3);
      end else if (!clean && pick >= 88) begin
        add_fault(k == chars - 1);
      end else if (pick < 40) begin
        s = ($urandom_range(0, 9) == 0) ? 21'h0A : 21'($urandom_range(0, 127));
        add_scalar(s, 1);
      end else if (pick < 58) begin
        add_scalar(21'($urandom_range(32'h80, 32'h7FF)), 2);
      end else if (pick < 76) begin
        s = 21'($urandom_range(32'h800, 32'hFFFF));
        if (s >= 21'hD800 && s <= 21'hDFFF) s = s ^ 21'h2000;
        add_scalar(s, 3);
      end else begin
        add_scalar(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
      end
    end
    foreach (text_buf[i])
      bytes_to_send.insert(bytes_to_send.size(), {text_buf[i], i == text_buf.size() - 1});
    bytes_built += text_buf.size();
    texts_built++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      quiet = (bytes_to_send.size() < QUIET_TAIL);
      if (push && !full) begin
        decode_byte(data_byte, end_of_text);
        bytes_taken++;
      end
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 10) - 1;
          push <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          {data_byte, end_of_text} <= bytes_to_send.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) check_result();
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // bit 8 marks the last byte of a text
  logic [8:0] directed [25] = '{
    9'h0EF, 9'h0BB, 9'h0BF, 9'h000, 9'h00A, 9'h07F,
    9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
    9'h0ED, 9'h0A0, 9'h180,
    9'h080, 9'h141,
    9'h0EF, 9'h0BB, 9'h1BF,
    9'h1FF,
    9'h0E2, 9'h182
  };

  initial begin
    restart_text();
    foreach (directed[i]) begin
      bytes_to_send.insert(bytes_to_send.size(), {directed[i][7:0], directed[i][8]});
      if (directed[i][8]) texts_built++;
    end
    bytes_built = $size(directed);
    while (bytes_built < BYTES_WANTED) build_text();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (bytes_to_send.size() != 0 || push) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d texts, %0d bytes sent in %0d cycles", texts_built, bytes_taken, cycles);
    $display("checked %0d code units, %0d error reports, %0d empty text ends",
             units_seen, errors_seen, ends_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
